### src/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the netstring deframer.
// ----------------------------------------------------------------------------
package nsd_pkg;

  localparam int LEN_WIDTH     = 16;
  localparam int MAX_LEN_WIDTH = 16;
  localparam int BYTE_WIDTH    = 8;
  localparam int ACC_WIDTH     = LEN_WIDTH + 4;
  localparam int CMP_WIDTH     = (ACC_WIDTH > MAX_LEN_WIDTH) ? ACC_WIDTH : MAX_LEN_WIDTH;

  localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = {MAX_LEN_WIDTH{1'b1}};
  localparam logic [LEN_WIDTH-1:0]     LEN_ALL_ONES  = {LEN_WIDTH{1'b1}};

  localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_WIDTH-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_WIDTH-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [3:0]            DEC_BASE   = 4'd10;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_LEN     = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_COMMA   = 3'b100
  } phase_t;

  typedef struct packed {
    logic                  valid;
    logic [BYTE_WIDTH-1:0] payload_byte;
    kind_t                 kind;
  } nsd_result_t;

endpackage

### src/nsd_byte_if.sv
// ----------------------------------------------------------------------------
// nsd_byte_if
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface nsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### src/nsd_result_if.sv
// ----------------------------------------------------------------------------
// nsd_result_if
// Valid/ready channel carrying one deframer result per transaction.
// ----------------------------------------------------------------------------
interface nsd_result_if;
  logic          valid;
  logic          ready;
  logic [7:0]    payload_byte;
  nsd_pkg::kind_t kind;

  modport source (output valid, output payload_byte, output kind, input ready);
  modport sink   (input valid, input payload_byte, input kind, output ready);
endinterface

### src/nsd_parser.sv
// ----------------------------------------------------------------------------
// nsd_parser
// Netstring parse state and the per-byte update of phase, length and count.
// ----------------------------------------------------------------------------
module nsd_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  logic [nsd_pkg::BYTE_WIDTH-1:0]      step_byte,
  input  logic [nsd_pkg::MAX_LEN_WIDTH-1:0]   max_length,
  output nsd_pkg::nsd_result_t                res
);
  import nsd_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [LEN_WIDTH-1:0] length_accum_r, length_accum_nxt;
  logic [LEN_WIDTH-1:0] bytes_left_r, bytes_left_nxt;
  logic                 digit_seen_r, digit_seen_nxt;

  logic [LEN_WIDTH-1:0] left_dec;
  logic [ACC_WIDTH-1:0] accum_next;
  logic [CMP_WIDTH-1:0] accum_cmp;
  logic [CMP_WIDTH-1:0] cfg_limit;
  logic [CMP_WIDTH-1:0] len_limit;
  logic [CMP_WIDTH-1:0] limit;
  logic [3:0]           digit_val;
  logic                 is_digit;

  assign is_digit   = (step_byte >= CHAR_ZERO) && (step_byte <= CHAR_NINE);
  assign digit_val  = 4'(step_byte - CHAR_ZERO);
  assign accum_next = (ACC_WIDTH'(length_accum_r) << 3) + (ACC_WIDTH'(length_accum_r) << 1)
                      + ACC_WIDTH'(digit_val);
  assign accum_cmp  = CMP_WIDTH'(accum_next);
  assign cfg_limit  = CMP_WIDTH'(max_length);
  assign len_limit  = CMP_WIDTH'(LEN_ALL_ONES);
  assign limit      = (cfg_limit < len_limit) ? cfg_limit : len_limit;
  assign left_dec   = bytes_left_r - LEN_WIDTH'(1);

  always_comb begin
    phase_nxt        = phase_r;
    length_accum_nxt = length_accum_r;
    bytes_left_nxt   = bytes_left_r;
    digit_seen_nxt   = digit_seen_r;
    res.valid        = 1'b0;
    res.payload_byte = '0;
    res.kind         = KIND_BYTE;
    case (phase_r)
      PH_PAYLOAD: begin
        bytes_left_nxt   = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_COMMA;
        end
        res.valid        = 1'b1;
        res.payload_byte = step_byte;
        res.kind         = KIND_BYTE;
      end
      PH_COMMA: begin
        phase_nxt        = PH_LEN;
        length_accum_nxt = '0;
        bytes_left_nxt   = '0;
        digit_seen_nxt   = 1'b0;
        if (step_byte == CHAR_COMMA) begin
          res.valid = (length_accum_r != '0);
          res.kind  = KIND_GOOD;
        end else begin
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
        end
      end
      default: begin
        if (is_digit && (accum_cmp <= limit)) begin
          phase_nxt        = PH_LEN;
          length_accum_nxt = LEN_WIDTH'(accum_next);
          digit_seen_nxt   = 1'b1;
        end else if (!is_digit && (step_byte == CHAR_COLON) && digit_seen_r) begin
          digit_seen_nxt = 1'b0;
          bytes_left_nxt = length_accum_r;
          phase_nxt      = (length_accum_r == '0) ? PH_COMMA : PH_PAYLOAD;
        end else begin
          phase_nxt        = PH_LEN;
          length_accum_nxt = '0;
          bytes_left_nxt   = '0;
          digit_seen_nxt   = 1'b0;
          res.valid        = 1'b1;
          res.kind         = KIND_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LEN;
      length_accum_r <= '0;
      bytes_left_r   <= '0;
      digit_seen_r   <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      length_accum_r <= length_accum_nxt;
      bytes_left_r   <= bytes_left_nxt;
      digit_seen_r   <= digit_seen_nxt;
    end
  end

endmodule

### src/netstring_deframer_core.sv
// ----------------------------------------------------------------------------
// netstring_deframer_core
// Streaming netstring deframer with per-byte payload output and frame status.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result register is empty or its result is
// being taken, and returns at most one result per byte: the byte sits in an
// input register, the parser updates its phase, length and count (the length
// step is a multiply by ten and an add with a compare against max_length), and
// the result lands in an output register that lets a new byte in while a result waits to be taken.
// Payload bytes come out with kind 0, a good closing comma gives kind 1 and any
// framing fault gives kind 2; bytes of a frame that ends in kind 2 are to be
// dropped downstream. An empty netstring gives no result.
module netstring_deframer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  nsd_byte_if.sink                           in_ch,
  nsd_result_if.source                       out_ch,
  input  logic                               cfg_wr_en,
  input  logic [nsd_pkg::MAX_LEN_WIDTH-1:0]  cfg_wr_data
);
  import nsd_pkg::*;

  logic [MAX_LEN_WIDTH-1:0] max_length_r;
  logic                     in_valid_r;
  logic [BYTE_WIDTH-1:0]    in_byte_r;
  logic                     out_valid_r;
  logic [BYTE_WIDTH-1:0]    out_byte_r;
  kind_t                    out_kind_r;
  logic                     advance;
  nsd_result_t              res;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.kind         = out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  nsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .step_byte  (in_byte_r),
    .max_length (max_length_r),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_byte_r <= res.payload_byte;
      out_kind_r <= res.kind;
    end
  end

endmodule
